// ----- rtl/core/dq_current_pi_with_vector_limit_defines.svh -----
// Assertion macros for the dq current PI controller.
// Included by modules that check their own control logic; no other dependency.
`ifndef DQ_CURRENT_PI_WITH_VECTOR_LIMIT_DEFINES_SVH
`define DQ_CURRENT_PI_WITH_VECTOR_LIMIT_DEFINES_SVH
`ifndef SYNTH
`define DQPI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
`define DQPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define DQPI_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define DQPI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/core/dqpi_pkg.sv -----
// Shared types and constants of the dq current PI controller.
// Used by the controller, the datapath and the top level; no dependencies.
package dqpi_pkg;

  // Signed width of the unlimited axis voltages (Q16 volts)
  localparam int VW = 57;

  typedef enum logic [2:0] {
    CFG_PROP_GAIN = 3'd0,
    CFG_INT_GAIN  = 3'd1,
    CFG_D_IND     = 3'd2,
    CFG_Q_IND     = 3'd3,
    CFG_FLUX      = 3'd4,
    CFG_CUR_LIM   = 3'd5
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PREP,
    S_MUL,
    S_TERM,
    S_SUM,
    S_MAG,
    S_SHIFT,
    S_SQUARE,
    S_TEST,
    S_BRANCH,
    S_SQRT,
    S_DIV_INIT,
    S_DIV,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic mul;
    logic term;
    logic sum;
    logic mag;
    logic shift;
    logic square;
    logic test;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic shift_more;
    logic limited;
  } dp_stat_t;

endpackage

// ----- rtl/core/dqpi_dp.sv -----
// Datapath of the dq current PI controller: config registers, PI terms,
// vector limit with bit-serial square root and divider. Depends on dqpi_pkg.
module dqpi_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_index,
  input  logic [31:0]          cfg_data,
  input  logic signed [31:0]   in_d_current_ref,
  input  logic signed [31:0]   in_q_current_ref,
  input  logic signed [31:0]   in_d_current_meas,
  input  logic signed [31:0]   in_q_current_meas,
  input  logic [30:0]          in_voltage_limit,
  input  logic signed [31:0]   in_elec_speed,
  input  dqpi_pkg::dp_cmd_t    cmd,
  output dqpi_pkg::dp_stat_t   stat,
  output logic signed [31:0]   out_d_voltage,
  output logic signed [31:0]   out_q_voltage,
  output logic                 out_limited
);
  import dqpi_pkg::*;

  function automatic logic signed [VW-1:0] apply_sign(input logic neg,
                                                      input logic [VW-2:0] mag);
    logic signed [VW-1:0] v;
    v = $signed({1'b0, mag});
    return neg ? -v : v;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [34:0] x);
    logic signed [34:0] hi;
    logic signed [34:0] lo;
    hi = 35'sd2147483647;
    lo = -35'sd2147483648;
    if (x > hi) return 32'sh7fffffff;
    if (x < lo) return 32'sh80000000;
    return x[31:0];
  endfunction

  // Configuration registers
  logic [23:0] kp_r;
  logic [31:0] ki_r;
  logic [31:0] ld_r;
  logic [31:0] lq_r;
  logic [31:0] flux_r;
  logic [30:0] ilim_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r   <= 24'd6554;
      ki_r   <= 32'd53687091;
      ld_r   <= 32'd85899;
      lq_r   <= 32'd107374;
      flux_r <= 32'd21474836;
      ilim_r <= 31'd327680;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_PROP_GAIN: kp_r   <= cfg_data[23:0];
        CFG_INT_GAIN:  ki_r   <= cfg_data;
        CFG_D_IND:     ld_r   <= cfg_data;
        CFG_Q_IND:     lq_r   <= cfg_data;
        CFG_FLUX:      flux_r <= cfg_data;
        CFG_CUR_LIM:   ilim_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Input capture
  logic signed [31:0] dref_r, qref_r, dmeas_r, qmeas_r, w_r;
  logic [30:0]        vlim_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dref_r  <= in_d_current_ref;
      qref_r  <= in_q_current_ref;
      dmeas_r <= in_d_current_meas;
      qmeas_r <= in_q_current_meas;
      vlim_r  <= in_voltage_limit;
      w_r     <= in_elec_speed;
    end
  end

  // Clamp references, errors, speed products
  logic signed [32:0] lim_p, lim_n, dref_x, qref_x, dref_c, qref_c;
  logic signed [32:0] ed_nxt, eq_nxt, ed_r, eq_r;
  logic signed [63:0] wq_nxt, wd_nxt, wq_r, wd_r;
  logic [31:0]        w_mag;
  logic [63:0]        wf_nxt, wf_r;

  always_comb begin
    lim_p  = $signed({2'b00, ilim_r});
    lim_n  = -lim_p;
    dref_x = {dref_r[31], dref_r};
    qref_x = {qref_r[31], qref_r};
    dref_c = (dref_x > lim_p) ? lim_p : ((dref_x < lim_n) ? lim_n : dref_x);
    qref_c = (qref_x > lim_p) ? lim_p : ((qref_x < lim_n) ? lim_n : qref_x);
    ed_nxt = dref_c - {dmeas_r[31], dmeas_r};
    eq_nxt = qref_c - {qmeas_r[31], qmeas_r};
    wq_nxt = w_r * qmeas_r;
    wd_nxt = w_r * dmeas_r;
    w_mag  = w_r[31] ? (~w_r + 32'd1) : w_r;
    wf_nxt = {32'd0, w_mag} * {32'd0, flux_r};
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      ed_r <= ed_nxt;
      eq_r <= eq_nxt;
      wq_r <= wq_nxt;
      wd_r <= wd_nxt;
      wf_r <= wf_nxt;
    end
  end

  // Partial products on magnitudes
  logic [32:0] ed_abs, eq_abs;
  logic [63:0] wq_abs, wd_abs;
  logic [55:0] kpd_p_r, kpq_p_r;
  logic [63:0] kid_p_r, kiq_p_r;
  logic [63:0] cq_lo_r, cd_lo_r;
  logic [62:0] cq_hi_r, cd_hi_r;

  always_comb begin
    ed_abs = ed_r[32] ? (~ed_r + 33'd1) : ed_r;
    eq_abs = eq_r[32] ? (~eq_r + 33'd1) : eq_r;
    wq_abs = wq_r[63] ? (~wq_r + 64'd1) : wq_r;
    wd_abs = wd_r[63] ? (~wd_r + 64'd1) : wd_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) begin
      kpd_p_r <= {24'd0, ed_abs[31:0]} * {32'd0, kp_r};
      kpq_p_r <= {24'd0, eq_abs[31:0]} * {32'd0, kp_r};
      kid_p_r <= {32'd0, ed_abs[31:0]} * {32'd0, ki_r};
      kiq_p_r <= {32'd0, eq_abs[31:0]} * {32'd0, ki_r};
      cq_lo_r <= {32'd0, wq_abs[31:0]} * {32'd0, lq_r};
      cq_hi_r <= {32'd0, wq_abs[62:32]} * {31'd0, lq_r};
      cd_lo_r <= {32'd0, wd_abs[31:0]} * {32'd0, ld_r};
      cd_hi_r <= {32'd0, wd_abs[62:32]} * {31'd0, ld_r};
    end
  end

  // Round each product to Q16, ties away from zero, and restore sign
  logic [94:0]          cq_full, cd_full;
  logic [55:0]          cq_mag, cd_mag;
  logic [40:0]          kpd_mag, kpq_mag, fl_mag;
  logic [32:0]          kid_mag, kiq_mag;
  logic signed [VW-1:0] kpd_t_r, kpq_t_r, cq_t_r, cd_t_r, fl_t_r;
  logic signed [33:0]   kid_t_r, kiq_t_r;

  always_comb begin
    cq_full = {cq_hi_r, 32'd0} + {31'd0, cq_lo_r};
    cd_full = {cd_hi_r, 32'd0} + {31'd0, cd_lo_r};
    cq_mag  = {1'b0, cq_full[94:40]} + {55'd0, cq_full[39]};
    cd_mag  = {1'b0, cd_full[94:40]} + {55'd0, cd_full[39]};
    kpd_mag = {1'b0, kpd_p_r[55:16]} + {40'd0, kpd_p_r[15]};
    kpq_mag = {1'b0, kpq_p_r[55:16]} + {40'd0, kpq_p_r[15]};
    fl_mag  = {1'b0, wf_r[63:24]} + {40'd0, wf_r[23]};
    kid_mag = {1'b0, kid_p_r[63:32]} + {32'd0, kid_p_r[31]};
    kiq_mag = {1'b0, kiq_p_r[63:32]} + {32'd0, kiq_p_r[31]};
  end

  always_ff @(posedge clk) begin
    if (cmd.term) begin
      kpd_t_r <= apply_sign(ed_r[32], {15'd0, kpd_mag});
      kpq_t_r <= apply_sign(eq_r[32], {15'd0, kpq_mag});
      cq_t_r  <= apply_sign(wq_r[63], cq_mag);
      cd_t_r  <= apply_sign(wd_r[63], cd_mag);
      fl_t_r  <= apply_sign(w_r[31], {15'd0, fl_mag});
      kid_t_r <= ed_r[32] ? -$signed({1'b0, kid_mag}) : $signed({1'b0, kid_mag});
      kiq_t_r <= eq_r[32] ? -$signed({1'b0, kiq_mag}) : $signed({1'b0, kiq_mag});
    end
  end

  // Unlimited axis voltages
  logic signed [31:0]   d_int_r, q_int_r;
  logic signed [VW-1:0] vd_u_r, vq_u_r;

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      vd_u_r <= kpd_t_r + {{(VW-32){d_int_r[31]}}, d_int_r} - cq_t_r;
      vq_u_r <= kpq_t_r + {{(VW-32){q_int_r[31]}}, q_int_r} + cd_t_r + fl_t_r;
    end
  end

  // Magnitudes, then shift both right together until each fits 31 bits
  logic [VW-1:0] vd_abs, vq_abs;
  logic [VW-2:0] ma_r, mb_r;
  logic          big_r;

  always_comb begin
    vd_abs = vd_u_r[VW-1] ? (~vd_u_r + VW'(1)) : vd_u_r;
    vq_abs = vq_u_r[VW-1] ? (~vq_u_r + VW'(1)) : vq_u_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.mag) begin
      ma_r  <= vd_abs[VW-2:0];
      mb_r  <= vq_abs[VW-2:0];
      big_r <= (|vd_abs[VW-2:31]) | (|vq_abs[VW-2:31]);
    end else if (cmd.shift) begin
      ma_r <= ma_r >> 1;
      mb_r <= mb_r >> 1;
    end
  end

  // Squares and limit test
  logic [61:0] sqa_r, sqb_r, vl2_r;
  logic [62:0] sumsq;
  logic        limited_r;

  assign sumsq = {1'b0, sqa_r} + {1'b0, sqb_r};

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      sqa_r <= {31'd0, ma_r[30:0]} * {31'd0, ma_r[30:0]};
      sqb_r <= {31'd0, mb_r[30:0]} * {31'd0, mb_r[30:0]};
      vl2_r <= {31'd0, vlim_r} * {31'd0, vlim_r};
    end
    if (cmd.test) begin
      limited_r <= big_r | (sumsq > {1'b0, vl2_r});
    end
  end

  // Square root, one root bit and two radicand bits per step
  logic [62:0] x_r, root_r, bit_r;
  logic [63:0] trial;

  assign trial = {1'b0, root_r} + {1'b0, bit_r};

  always_ff @(posedge clk) begin
    if (cmd.test) begin
      x_r    <= sumsq;
      root_r <= '0;
      bit_r  <= {1'b1, 62'd0};
    end else if (cmd.sqrt_step) begin
      if ({1'b0, x_r} >= trial) begin
        x_r    <= x_r - trial[62:0];
        root_r <= (root_r >> 1) + bit_r;
      end else begin
        root_r <= root_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // Two restoring divider lanes; the low word turns into the quotient
  logic [31:0] dvs, dvs_r;
  logic [62:0] na, nb;
  logic [31:0] rem_a_r, rem_b_r, quo_a_r, quo_b_r;
  logic [32:0] ra2, rb2, ra_sub, rb_sub;
  logic        qa_bit, qb_bit;

  always_comb begin
    dvs    = (root_r[31:0] == 32'd0) ? 32'd1 : root_r[31:0];
    na     = {1'b0, {31'd0, ma_r[30:0]} * {31'd0, vlim_r}} + {32'd0, dvs[31:1]};
    nb     = {1'b0, {31'd0, mb_r[30:0]} * {31'd0, vlim_r}} + {32'd0, dvs[31:1]};
    ra2    = {rem_a_r, quo_a_r[31]};
    rb2    = {rem_b_r, quo_b_r[31]};
    ra_sub = ra2 - {1'b0, dvs_r};
    rb_sub = rb2 - {1'b0, dvs_r};
    qa_bit = (ra2 >= {1'b0, dvs_r});
    qb_bit = (rb2 >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      dvs_r   <= dvs;
      rem_a_r <= {1'b0, na[62:32]};
      rem_b_r <= {1'b0, nb[62:32]};
      quo_a_r <= na[31:0];
      quo_b_r <= nb[31:0];
    end else if (cmd.div_step) begin
      rem_a_r <= qa_bit ? ra_sub[31:0] : ra2[31:0];
      rem_b_r <= qb_bit ? rb_sub[31:0] : rb2[31:0];
      quo_a_r <= {quo_a_r[30:0], qa_bit};
      quo_b_r <= {quo_b_r[30:0], qb_bit};
    end
  end

  // Commit: integrators with anti-windup, output register
  logic               d_upd, q_upd;
  logic signed [34:0] d_sum, q_sum;
  logic signed [31:0] vd_lim, vq_lim;

  always_comb begin
    d_upd  = !limited_r ||
             (ed_r[32] && !vd_u_r[VW-1] && (vd_u_r != '0)) ||
             (!ed_r[32] && (ed_r != '0) && vd_u_r[VW-1]);
    q_upd  = !limited_r ||
             (eq_r[32] && !vq_u_r[VW-1] && (vq_u_r != '0)) ||
             (!eq_r[32] && (eq_r != '0) && vq_u_r[VW-1]);
    d_sum  = {{3{d_int_r[31]}}, d_int_r} + {kid_t_r[33], kid_t_r};
    q_sum  = {{3{q_int_r[31]}}, q_int_r} + {kiq_t_r[33], kiq_t_r};
    vd_lim = vd_u_r[VW-1] ? -$signed(quo_a_r) : $signed(quo_a_r);
    vq_lim = vq_u_r[VW-1] ? -$signed(quo_b_r) : $signed(quo_b_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_int_r <= '0;
      q_int_r <= '0;
    end else if (cmd.commit) begin
      if (d_upd) d_int_r <= sat32(d_sum);
      if (q_upd) q_int_r <= sat32(q_sum);
    end
  end

  // An unlimited vector already fits 31 bits of magnitude
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_d_voltage <= limited_r ? vd_lim : vd_u_r[31:0];
      out_q_voltage <= limited_r ? vq_lim : vq_u_r[31:0];
      out_limited   <= limited_r;
    end
  end

  assign stat.shift_more = (|ma_r[VW-2:31]) | (|mb_r[VW-2:31]);
  assign stat.limited    = limited_r;

endmodule

// ----- rtl/core/dqpi_ctrl.sv -----
// Sequencer of the dq current PI controller: steps the datapath, counts
// square root and divider iterations, owns the output valid. Uses dqpi_pkg.
`include "dq_current_pi_with_vector_limit_defines.svh"
module dqpi_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  dqpi_pkg::dp_stat_t  stat,
  output dqpi_pkg::dp_cmd_t   cmd
);
  import dqpi_pkg::*;

  state_t     state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign out_free = !out_valid_r || out_ready;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:     if (in_valid) state_nxt = S_PREP;
      S_PREP:     state_nxt = S_MUL;
      S_MUL:      state_nxt = S_TERM;
      S_TERM:     state_nxt = S_SUM;
      S_SUM:      state_nxt = S_MAG;
      S_MAG:      state_nxt = S_SHIFT;
      S_SHIFT:    if (!stat.shift_more) state_nxt = S_SQUARE;
      S_SQUARE:   state_nxt = S_TEST;
      S_TEST:     state_nxt = S_BRANCH;
      S_BRANCH:   state_nxt = stat.limited ? S_SQRT : S_DONE;
      S_SQRT:     if (cnt_r == 5'd31) state_nxt = S_DIV_INIT;
      S_DIV_INIT: state_nxt = S_DIV;
      S_DIV:      if (cnt_r == 5'd31) state_nxt = S_DONE;
      S_DONE:     if (out_free) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Iteration counter wraps back to zero at the end of each loop
  always_comb begin
    cnt_nxt = (state_r == S_SQRT || state_r == S_DIV) ? cnt_r + 5'd1 : 5'd0;
  end

  // Datapath commands
  always_comb begin
    cmd           = '0;
    cmd.load      = (state_r == S_IDLE) && in_valid;
    cmd.prep      = (state_r == S_PREP);
    cmd.mul       = (state_r == S_MUL);
    cmd.term      = (state_r == S_TERM);
    cmd.sum       = (state_r == S_SUM);
    cmd.mag       = (state_r == S_MAG);
    cmd.shift     = (state_r == S_SHIFT) && stat.shift_more;
    cmd.square    = (state_r == S_SQUARE);
    cmd.test      = (state_r == S_TEST);
    cmd.sqrt_step = (state_r == S_SQRT);
    cmd.div_init  = (state_r == S_DIV_INIT);
    cmd.div_step  = (state_r == S_DIV);
    cmd.commit    = (state_r == S_DONE) && out_free;
  end

  // Hold the result until the output transfer
  always_comb begin
    if (cmd.commit) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  `DQPI_ASSERT_IMP(a_sqrt_only_limited, clk, rst_n, state_r == S_SQRT, stat.limited)
  `DQPI_ASSERT_IMP(a_cnt_outside_loops, clk, rst_n, state_r != S_SQRT && state_r != S_DIV, cnt_r == 5'd0)
  `DQPI_ASSERT_NEXT(a_commit_sets_valid, clk, rst_n, cmd.commit, out_valid_r && state_r == S_IDLE)

endmodule

// ----- rtl/core/dq_current_pi_with_vector_limit.sv -----
// dq current PI controller with decoupling and voltage vector limit. One
// transfer in gives one result out. An item whose voltage vector stays
// inside the limit skips the square root and the dividers. A limited item
// also halves an oversized vector (up to 25 halvings), then runs a
// bit-serial square root and two parallel restoring dividers. A new item is
// taken in the cycle after the result is loaded into the output register;
// the result then waits there for the output transfer. Config writes are
// taken at any time and should only be issued while the block is idle.
// Depends on dqpi_pkg, dqpi_ctrl and dqpi_dp.
module dq_current_pi_with_vector_limit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [31:0]  in_d_current_ref,
  input  logic signed [31:0]  in_q_current_ref,
  input  logic signed [31:0]  in_d_current_meas,
  input  logic signed [31:0]  in_q_current_meas,
  input  logic [30:0]         in_voltage_limit,
  input  logic signed [31:0]  in_elec_speed,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [31:0]  out_d_voltage,
  output logic signed [31:0]  out_q_voltage,
  output logic                out_limited
);
  import dqpi_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Config registers accept every cycle
  assign cfg_ready = 1'b1;

  dqpi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  dqpi_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_d_current_ref  (in_d_current_ref),
    .in_q_current_ref  (in_q_current_ref),
    .in_d_current_meas (in_d_current_meas),
    .in_q_current_meas (in_q_current_meas),
    .in_voltage_limit  (in_voltage_limit),
    .in_elec_speed     (in_elec_speed),
    .cmd               (cmd),
    .stat              (stat),
    .out_d_voltage     (out_d_voltage),
    .out_q_voltage     (out_q_voltage),
    .out_limited       (out_limited)
  );

endmodule

// ----- tb/sv/dq_current_pi_with_vector_limit_checker.sv -----
// Checker for the dq current PI controller: watches the config, input and
// result channels, predicts every result and compares it field by field.
// Depends on dqpi_pkg for the register index codes.
module dq_current_pi_with_vector_limit_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_d_current_ref,
  input  logic signed [31:0] in_q_current_ref,
  input  logic signed [31:0] in_d_current_meas,
  input  logic signed [31:0] in_q_current_meas,
  input  logic [30:0]        in_voltage_limit,
  input  logic signed [31:0] in_elec_speed,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic signed [31:0] out_d_voltage,
  input  logic signed [31:0] out_q_voltage,
  input  logic               out_limited,
  output int                 fail_count,
  output int                 volts_pending,
  output int                 volts_checked,
  output int                 limited_seen
);
  timeunit 1ns;
  timeprecision 1ps;
  import dqpi_pkg::*;

  typedef struct packed {
    logic signed [31:0] vd;
    logic signed [31:0] vq;
    logic               limited;
  } volts_t;

  // controller registers and integrators as the block should hold them
  logic [23:0] kp;
  logic [31:0] ki_ts;
  logic [31:0] ld;
  logic [31:0] lq;
  logic [31:0] flux;
  logic [30:0] i_lim;
  longint      d_acc;
  longint      q_acc;
  volts_t      volts_q[$];

  assign volts_pending = volts_q.size();

  // product magnitude rounded to nearest after dropping s bits, sign restored
  function automatic longint round_mul(longint a, logic [63:0] u, int s);
    logic [63:0]  m;
    logic [127:0] p;
    logic [127:0] r;
    m = (a < 0) ? 64'(-a) : 64'(a);
    p = {64'd0, m} * {64'd0, u};
    r = (p >> s) + ((p >> (s - 1)) & 128'd1);
    return (a < 0) ? -longint'(r[63:0]) : longint'(r[63:0]);
  endfunction

  function automatic longint sat32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic bit pulls_back(longint e, longint v);
    return (e < 0 && v > 0) || (e > 0 && v < 0);
  endfunction

  // one PWM period of the controller: returns the voltages, updates integrators
  function automatic volts_t control_step();
    volts_t      res;
    longint      lim, dref, qref, dm, qm, w, vl, ed, eq, vd_u, vq_u, vd, vq;
    logic [63:0] ma, mb, sumsq, vl2, m;
    bit          lim_hit;
    lim  = longint'(i_lim);
    dref = in_d_current_ref;
    qref = in_q_current_ref;
    dm   = in_d_current_meas;
    qm   = in_q_current_meas;
    w    = in_elec_speed;
    vl   = longint'(in_voltage_limit);
    if (dref > lim) dref = lim;
    if (dref < -lim) dref = -lim;
    if (qref > lim) qref = lim;
    if (qref < -lim) qref = -lim;
    ed = dref - dm;
    eq = qref - qm;
    vd_u = round_mul(ed, 64'(kp), 16) + d_acc - round_mul(w * qm, 64'(lq), 40);
    vq_u = round_mul(eq, 64'(kp), 16) + q_acc + round_mul(w * dm, 64'(ld), 40)
         + round_mul(w, 64'(flux), 24);
    ma = (vd_u < 0) ? 64'(-vd_u) : 64'(vd_u);
    mb = (vq_u < 0) ? 64'(-vq_u) : 64'(vq_u);
    lim_hit = (ma >= 64'h8000_0000) || (mb >= 64'h8000_0000);
    // halve an oversized vector until both parts fit in 31 bits
    while (ma >= 64'h8000_0000 || mb >= 64'h8000_0000) begin
      ma = ma >> 1;
      mb = mb >> 1;
    end
    sumsq = ma * ma + mb * mb;
    vl2 = 64'(vl) * 64'(vl);
    lim_hit = lim_hit || (sumsq > vl2);
    if (lim_hit) begin
      m = floor_sqrt(sumsq);
      if (m == 0) m = 1;
      vd = longint'((ma * 64'(vl) + m / 2) / m);
      vq = longint'((mb * 64'(vl) + m / 2) / m);
      if (vd_u < 0) vd = -vd;
      if (vq_u < 0) vq = -vq;
      // anti-windup: accumulate only where the error pulls the axis back
      if (pulls_back(ed, vd_u)) d_acc = sat32(d_acc + round_mul(ed, 64'(ki_ts), 32));
      if (pulls_back(eq, vq_u)) q_acc = sat32(q_acc + round_mul(eq, 64'(ki_ts), 32));
    end else begin
      vd = vd_u;
      vq = vq_u;
      d_acc = sat32(d_acc + round_mul(ed, 64'(ki_ts), 32));
      q_acc = sat32(q_acc + round_mul(eq, 64'(ki_ts), 32));
    end
    res.vd = 32'(sat32(vd));
    res.vq = 32'(sat32(vq));
    res.limited = lim_hit;
    return res;
  endfunction

  // track registers, predict on input transfers, compare on result transfers
  always @(posedge clk) begin
    volts_t want;
    if (!rst_n) begin
      kp = 24'd6554;
      ki_ts = 32'd53687091;
      ld = 32'd85899;
      lq = 32'd107374;
      flux = 32'd21474836;
      i_lim = 31'd327680;
      d_acc = 0;
      q_acc = 0;
      volts_q.delete();
      fail_count = 0;
      volts_checked = 0;
      limited_seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PROP_GAIN: kp = cfg_data[23:0];
          CFG_INT_GAIN:  ki_ts = cfg_data;
          CFG_D_IND:     ld = cfg_data;
          CFG_Q_IND:     lq = cfg_data;
          CFG_FLUX:      flux = cfg_data;
          CFG_CUR_LIM:   i_lim = cfg_data[30:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) volts_q.push_back(control_step());
      if (out_valid && out_ready) begin
        if (volts_q.size() == 0) begin
          $display("%0t: result with nothing expected: vd=%0d vq=%0d limited=%0b",
                   $time, out_d_voltage, out_q_voltage, out_limited);
          fail_count++;
        end else begin
          want = volts_q.pop_front();
          volts_checked++;
          if (out_limited) limited_seen++;
          if (out_d_voltage !== want.vd) begin
            $display("%0t: d_voltage expected %0d actual %0d", $time, want.vd,
                     out_d_voltage);
            fail_count++;
          end
          if (out_q_voltage !== want.vq) begin
            $display("%0t: q_voltage expected %0d actual %0d", $time, want.vq,
                     out_q_voltage);
            fail_count++;
          end
          if (out_limited !== want.limited) begin
            $display("%0t: limited expected %0b actual %0b", $time, want.limited,
                     out_limited);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ----- tb/sv/dq_current_pi_with_vector_limit_tb.sv -----
// Top of the dq current PI controller testbench: clock, reset, stimulus on
// the config and input channels, result back-pressure and the verdict.
// Depends on dqpi_pkg, the controller RTL and the checker module.
module dq_current_pi_with_vector_limit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import dqpi_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int NUM_PHASES = 6;
  localparam int ITEMS_PER_PHASE = 180;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = '0;
  logic [31:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [31:0] in_d_current_ref = '0;
  logic signed [31:0] in_q_current_ref = '0;
  logic signed [31:0] in_d_current_meas = '0;
  logic signed [31:0] in_q_current_meas = '0;
  logic [30:0]        in_voltage_limit = '0;
  logic signed [31:0] in_elec_speed = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [31:0] out_d_voltage;
  logic signed [31:0] out_q_voltage;
  logic               out_limited;

  int fail_count;
  int volts_pending;
  int volts_checked;
  int limited_seen;
  int items_sent = 0;
  int quiet_cycles = 0;
  bit no_gaps = 1'b0;
  bit hold_off_req = 1'b0;

  always #5 clk = ~clk;

  dq_current_pi_with_vector_limit uut (.*);

  dq_current_pi_with_vector_limit_checker chk (.*);

  // watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off when asked
  initial begin
    int stall;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    stall = 0;
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall = 400;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      stall = no_gaps ? 0 : $urandom_range(0, 10);
    end
  end

  function automatic logic signed [31:0] pick_field(int span);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return ($urandom_range(0, 1) != 0) ? 32'sh7fff_ffff : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  function automatic logic [30:0] pick_vlim();
    case ($urandom_range(0, 9))
      0: return 31'd0;
      1: return 31'($urandom);
      2: return 31'h7fff_ffff;
      default: return 31'($urandom_range(0, 1 << 22));
    endcase
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic send_item(logic signed [31:0] dref, logic signed [31:0] qref,
                           logic signed [31:0] dmeas, logic signed [31:0] qmeas,
                           logic [30:0] vlim, logic signed [31:0] speed);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_d_current_ref <= dref;
    in_q_current_ref <= qref;
    in_d_current_meas <= dmeas;
    in_q_current_meas <= qmeas;
    in_voltage_limit <= vlim;
    in_elec_speed <= speed;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // wait for every result, then let the block settle before touching config
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (volts_pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic load_phase(int ph);
    case (ph)
      1: begin
        write_reg(CFG_PROP_GAIN, 32'hff_ffff);
        write_reg(CFG_INT_GAIN, 32'hffff_ffff);
        write_reg(CFG_D_IND, 32'hffff_ffff);
        write_reg(CFG_Q_IND, 32'hffff_ffff);
        write_reg(CFG_FLUX, 32'hffff_ffff);
        write_reg(CFG_CUR_LIM, 32'h7fff_ffff);
      end
      2: begin
        write_reg(CFG_PROP_GAIN, 32'd0);
        write_reg(CFG_INT_GAIN, 32'd0);
        write_reg(CFG_D_IND, 32'd0);
        write_reg(CFG_Q_IND, 32'd0);
        write_reg(CFG_FLUX, 32'd0);
        write_reg(CFG_CUR_LIM, 32'd0);
      end
      3: begin
        write_reg(CFG_PROP_GAIN, $urandom);
        write_reg(CFG_INT_GAIN, $urandom);
        write_reg(CFG_D_IND, $urandom);
        write_reg(CFG_Q_IND, $urandom);
        write_reg(CFG_FLUX, $urandom);
        write_reg(CFG_CUR_LIM, $urandom);
      end
      4: begin
        write_reg(CFG_PROP_GAIN, $urandom_range(0, 1 << 18));
        write_reg(CFG_INT_GAIN, $urandom_range(0, 1 << 28));
        write_reg(CFG_D_IND, $urandom_range(0, 1 << 20));
        write_reg(CFG_Q_IND, $urandom_range(0, 1 << 20));
        write_reg(CFG_FLUX, $urandom_range(0, 1 << 26));
        write_reg(CFG_CUR_LIM, $urandom_range(0, 1 << 22));
      end
      default: begin
        write_reg(CFG_PROP_GAIN, 32'd6554);
        write_reg(CFG_INT_GAIN, 32'd53687091);
        write_reg(CFG_D_IND, 32'd85899);
        write_reg(CFG_Q_IND, 32'd107374);
        write_reg(CFG_FLUX, 32'd21474836);
        write_reg(CFG_CUR_LIM, 32'd327680);
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  // stimulus: directed corners at reset settings, then random phases
  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // small errors, in range
    send_item(32'sd65536, 32'sd131072, 32'sd60000, 32'sd100000, 31'd1 << 24, 32'sd25600);
    // zero error holds nothing but adds zero
    send_item(32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd1 << 20, 32'sd0);
    // references beyond the current clamp, both signs
    send_item(32'sh7fff_ffff, 32'sh8000_0000, 32'sd0, 32'sd0, 31'h7fff_ffff, 32'sd0);
    send_item(32'sh8000_0000, 32'sh7fff_ffff, 32'sd0, 32'sd0, 31'h7fff_ffff, 32'sd0);
    // extreme measurements and speeds: oversized vector gets halved
    send_item(32'sd0, 32'sd0, 32'sh7fff_ffff, 32'sh8000_0000, 31'd1 << 16, 32'sh7fff_ffff);
    send_item(32'sd0, 32'sd0, 32'sh8000_0000, 32'sh7fff_ffff, 31'd1 << 16, 32'sh8000_0000);
    send_item(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000,
              31'h7fff_ffff, 32'sh7fff_ffff);
    // zero voltage limit: nonzero vector collapses to zero
    send_item(32'sd65536, 32'sd65536, 32'sd0, 32'sd0, 31'd0, 32'sd0);
    // zero voltage limit with zero inputs
    send_item(32'sd0, 32'sd0, 32'sd0, 32'sd0, 31'd0, 32'sd0);
    // small limits exceeded by a d-axis and a q-axis error
    send_item(32'sd200000, 32'sd0, 32'sd0, 32'sd0, 31'd1, 32'sd0);
    send_item(32'sd0, -32'sd200000, 32'sd0, 32'sd0, 31'd3, 32'sd1000);
    // push the integrators hard with full-scale errors
    for (int i = 0; i < 8; i++)
      send_item(32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff,
                31'h7fff_ffff, 32'sd0);
    // error opposing the limited voltage lets it accumulate
    send_item(32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000,
              31'd1000, -32'sd1);
    drain();

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      load_phase(ph);
      no_gaps = (ph == 2 || ph == 4);
      if (ph == 1) hold_off_req = 1'b1;
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_item(pick_field(1 << 21), pick_field(1 << 21), pick_field(1 << 21),
                  pick_field(1 << 21), pick_vlim(), pick_field(1 << 19));
      drain();
    end

    $display("sent %0d items over %0d register settings; %0d results checked, %0d limited",
             items_sent, NUM_PHASES + 1, volts_checked, limited_seen);
    if (fail_count == 0 && volts_pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
